@@ src/assert_macros.svh @@
// Assertion macros used by the frame counter timestamp tracker top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define FTT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FTT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ftt_pkg.sv @@
// Types, constants and register indexes of the frame counter timestamp tracker.
`timescale 1ns / 1ps
package ftt_pkg;

  localparam int SECONDS_BITS_DEF = 32;
  localparam int CNT_W            = 16;
  localparam int CFG_W            = 16;
  localparam int CFG_IDX_W        = 8;
  localparam int SECS_IN_W        = 32;
  localparam int DIVIDEND_W       = 32;
  localparam int DIV_STEPS        = DIVIDEND_W;
  localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_SECONDS_PER_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_PERIOD    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROLLOVER_THRESHOLD = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ADVANCE_LIMIT      = CFG_IDX_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_POST,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    PATH_FIRST,
    PATH_REANCHOR,
    PATH_WRAP,
    PATH_ADVANCE,
    PATH_HOLD
  } path_t;

  typedef struct packed {
    logic load_in;
    logic prep;
    logic div_step;
    logic mul;
    logic post;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    path_t path;
    logic  div_last;
    logic  out_free;
  } dp_stat_t;

endpackage

@@ src/ftt_in_if.sv @@
// Request channel carrying one minor frame into the tracker.
`timescale 1ns / 1ps
interface ftt_in_if;
  import ftt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CNT_W-1:0]     frame_counter;
  logic [SECS_IN_W-1:0] now_seconds;
  modport source (output valid, output frame_counter, output now_seconds, input ready);
  modport sink (input valid, input frame_counter, input now_seconds, output ready);
endinterface

@@ src/ftt_out_if.sv @@
// Result channel carrying the anchor after each minor frame.
`timescale 1ns / 1ps
interface ftt_out_if;
  import ftt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 anchor_changed;
  logic [CNT_W-1:0]     anchor_counter;
  logic [SECS_IN_W-1:0] anchor_seconds;
  logic [CNT_W-1:0]     expected_next;
  modport source (output valid, output anchor_changed, output anchor_counter,
                  output anchor_seconds, output expected_next, input ready);
  modport sink (input valid, input anchor_changed, input anchor_counter,
                input anchor_seconds, input expected_next, output ready);
endinterface

@@ src/ftt_cfg_if.sv @@
// Register write channel of the tracker.
`timescale 1ns / 1ps
interface ftt_cfg_if;
  import ftt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/ftt_ctrl.sv @@
// Controller state machine that sequences one request through the datapath.
`timescale 1ns / 1ps
module ftt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ftt_pkg::dp_stat_t stat,
  output ftt_pkg::ctl_cmd_t cmd
);
  import ftt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.path inside {PATH_WRAP, PATH_ADVANCE}) state_nxt = ST_PREP;
        else state_nxt = ST_POST;
      end
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (stat.div_last) state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_POST;
      ST_POST: state_nxt = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_PREP:  cmd.prep     = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_MUL:   cmd.mul      = 1'b1;
      ST_POST:  cmd.post     = 1'b1;
      ST_DONE:  cmd.out_load = stat.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ src/ftt_datapath.sv @@
// Datapath: registers, anchor update, shared divider and the result register.
`timescale 1ns / 1ps
module ftt_datapath #(
  parameter int SECONDS_BITS = ftt_pkg::SECONDS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ftt_pkg::CNT_W-1:0]     in_frame_counter,
  input  logic [ftt_pkg::SECS_IN_W-1:0] in_now_seconds,
  ftt_cfg_if.sink                       cfg,
  ftt_out_if.source                     out_ch,
  input  ftt_pkg::ctl_cmd_t             cmd,
  output ftt_pkg::dp_stat_t             stat
);
  import ftt_pkg::*;

  logic [CFG_W-1:0] spp_r, rpp_r, rt_r, al_r;

  logic [CNT_W-1:0]        ctr_r;
  logic [SECS_IN_W-1:0]    now_r;
  logic                    valid_r;
  logic [CNT_W-1:0]        acnt_r;
  logic [SECONDS_BITS-1:0] asec_r;
  logic                    chg_r;

  logic [DIVIDEND_W-1:0] dvd_r;
  logic [CNT_W-1:0]      rem_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]      qd_r;
  logic [2*CNT_W-1:0]    sq_r;
  logic                  neg_r;

  logic                  out_valid_r;
  logic                  out_changed_r;
  logic [CNT_W-1:0]      out_cnt_r;
  logic [SECS_IN_W-1:0]  out_sec_r;
  logic [CNT_W-1:0]      out_next_r;

  logic [CNT_W-1:0]       dvs;
  logic [CNT_W-1:0]       diff;
  logic [CNT_W+1:0]       frames;
  logic                   frames_neg;
  logic [CNT_W:0]         mag;
  logic [DIVIDEND_W-1:0]  wrap_prod;
  logic [CNT_W:0]         rem_sh;
  logic                   rem_ge;
  logic [CNT_W-1:0]       qd_full;
  logic [SECONDS_BITS-1:0] step_secs;
  path_t                  path;

  // A divisor of zero behaves as one.
  assign dvs  = (rpp_r == '0) ? CNT_W'(1) : rpp_r;
  assign diff = ctr_r - acnt_r;

  // Frames left up to the wrap; may be negative when the threshold is large.
  assign frames     = (CNT_W+2)'(1 << CNT_W) - {2'b00, acnt_r} - {2'b00, rt_r};
  assign frames_neg = frames[CNT_W+1];
  assign mag        = frames_neg ? (CNT_W+1)'(-frames) : frames[CNT_W:0];
  assign wrap_prod  = DIVIDEND_W'(spp_r) * DIVIDEND_W'(mag);

  always_comb begin
    if (!valid_r) begin
      path = PATH_FIRST;
    end else if (ctr_r < acnt_r) begin
      path = (ctr_r < rt_r) ? PATH_REANCHOR : PATH_WRAP;
    end else if ((ctr_r > acnt_r) && (diff > al_r)) begin
      path = PATH_ADVANCE;
    end else begin
      path = PATH_HOLD;
    end
  end

  assign rem_sh    = {rem_r, dvd_r[DIVIDEND_W-1]};
  assign rem_ge    = rem_sh >= {1'b0, dvs};
  assign qd_full   = dvd_r[CNT_W-1:0] * dvs;
  assign step_secs = SECONDS_BITS'(dvd_r);

  assign stat.path     = path;
  assign stat.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat.out_free = !out_valid_r || out_ch.ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r <= CFG_W'(1);
      rpp_r <= CFG_W'(1);
      rt_r  <= '0;
      al_r  <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SECONDS_PER_PERIOD: spp_r <= cfg.data;
        REG_ROWS_PER_PERIOD:    rpp_r <= cfg.data;
        REG_ROLLOVER_THRESHOLD: rt_r  <= cfg.data;
        REG_ADVANCE_LIMIT:      al_r  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ctr_r <= in_frame_counter;
      now_r <= in_now_seconds;
    end
  end

  // Restoring divider: one quotient bit per cycle shifts into the dividend.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dvd_r <= (path == PATH_WRAP) ? wrap_prod
                                   : {{(DIVIDEND_W-CNT_W){1'b0}}, diff};
      neg_r <= frames_neg;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DIVIDEND_W-2:0], rem_ge};
      rem_r <= rem_ge ? CNT_W'(rem_sh - {1'b0, dvs}) : rem_sh[CNT_W-1:0];
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      qd_r <= qd_full;
      sq_r <= (2*CNT_W)'(spp_r) * (2*CNT_W)'(dvd_r[CNT_W-1:0]);
    end
  end

  // The path is taken before the anchor moves, since it is decided from the old anchor.
  always_ff @(posedge clk) begin
    if (cmd.post) begin
      chg_r <= (path != PATH_HOLD);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      acnt_r  <= '0;
      asec_r  <= '0;
    end else if (cmd.post) begin
      case (path)
        PATH_FIRST, PATH_REANCHOR: begin
          valid_r <= 1'b1;
          acnt_r  <= ctr_r;
          asec_r  <= SECONDS_BITS'(now_r);
        end
        PATH_WRAP: begin
          acnt_r <= '0;
          asec_r <= neg_r ? (asec_r - step_secs) : (asec_r + step_secs);
        end
        PATH_ADVANCE: begin
          acnt_r <= acnt_r + qd_r;
          asec_r <= asec_r + SECONDS_BITS'(sq_r);
        end
        default: ;
      endcase
    end
  end

  // Result register; the next request may be taken while it waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_changed_r <= chg_r;
      out_cnt_r     <= acnt_r;
      out_sec_r     <= asec_r[SECS_IN_W-1:0];
      out_next_r    <= ctr_r + CNT_W'(1);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.anchor_changed = out_changed_r;
  assign out_ch.anchor_counter = out_cnt_r;
  assign out_ch.anchor_seconds = out_sec_r;
  assign out_ch.expected_next  = out_next_r;

endmodule

@@ src/frame_counter_timestamp_tracker.sv @@
// Top level of the frame counter timestamp tracker.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
// in_if takes one minor frame per request: the 16-bit frame counter and the
// current time in seconds. out_if returns exactly one result per request:
// whether the anchor changed, the anchor counter and seconds after the frame,
// and the next expected counter. cfg_if writes the four period and threshold
// registers by index and is always ready. The user must ensure it is written
// only while idle; the block itself does not enforce this. A frame that
// re-anchors, is the first frame or leaves the anchor alone goes straight to
// the anchor update; a wrap-around or an anchor advance first passes a setup
// step, the shared restoring divider, which resolves one quotient bit per
// cycle, and a multiply step. One request is processed at a time, and a new
// one is taken once the last result is in the output register. The next
// request is accepted while that result waits; a stalled receiver holds back
// only the hand-off of the following result. Reset clears the anchor, marks
// it invalid, restores the register defaults and empties the output register.
module frame_counter_timestamp_tracker #(
  parameter int SECONDS_BITS = ftt_pkg::SECONDS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ftt_in_if.sink     in_if,
  ftt_out_if.source  out_if,
  ftt_cfg_if.sink    cfg_if
);
  import ftt_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  ftt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ftt_datapath #(
    .SECONDS_BITS (SECONDS_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_frame_counter (in_if.frame_counter),
    .in_now_seconds   (in_if.now_seconds),
    .cfg              (cfg_if),
    .out_ch           (out_if),
    .cmd              (cmd),
    .stat             (stat)
  );

  // A taken request keeps the input closed while it is processed.
  `FTT_ASSERT(a_busy_after_accept, clk, rst_n, (in_if.valid && in_if.ready) |=> !in_if.ready, "request accepted while busy")
  // A new result never overwrites one the receiver has not taken.
  `FTT_ASSERT(a_load_when_free, clk, rst_n, cmd.out_load |-> stat.out_free, "result register overwritten")
  // A taken result leaves the channel empty unless a new one is loaded.
  `FTT_ASSERT(a_result_once, clk, rst_n, (out_if.valid && out_if.ready && !cmd.out_load) |=> !out_if.valid, "result delivered twice")
  // Reset empties the result register.
  `FTT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_if.valid, "result valid after reset")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the frame counter timestamp tracker.
`timescale 1ns / 1ps
module testbench;
  import ftt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int FRAMES_PER_PHASE = 100;

  typedef struct {
    logic                 changed;
    logic [CNT_W-1:0]     counter;
    logic [SECS_IN_W-1:0] seconds;
    logic [CNT_W-1:0]     next_count;
  } anchor_result_t;

  // Tracks the anchor the block should hold and queues the result of each frame.
  class anchor_checker;
    bit                   have_anchor;
    bit [CNT_W-1:0]       anc_count;
    bit [SECS_IN_W-1:0]   anc_secs;
    bit [CFG_W-1:0]       secs_per_period;
    bit [CFG_W-1:0]       rows_per_period;
    bit [CFG_W-1:0]       rollover;
    bit [CFG_W-1:0]       lead_limit;
    anchor_result_t       pending_anchors[$];
    int                   errors;

    function new();
      have_anchor = 1'b0;
      anc_count = '0;
      anc_secs = '0;
      secs_per_period = CFG_W'(1);
      rows_per_period = CFG_W'(1);
      rollover = '0;
      lead_limit = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SECONDS_PER_PERIOD: secs_per_period = data;
        REG_ROWS_PER_PERIOD:    rows_per_period = data;
        REG_ROLLOVER_THRESHOLD: rollover = data;
        REG_ADVANCE_LIMIT:      lead_limit = data;
        default: ;
      endcase
    endfunction

    function void note_frame(logic [CNT_W-1:0] ctr, logic [SECS_IN_W-1:0] now);
      anchor_result_t r;
      longint frames;
      longint step_secs;
      int unsigned div;
      int unsigned lead;
      int unsigned quot;
      div = (rows_per_period == 0) ? 1 : rows_per_period;
      r.changed = 1'b0;
      if (!have_anchor) begin
        anc_count = ctr;
        anc_secs = now;
        have_anchor = 1'b1;
        r.changed = 1'b1;
      end else if (ctr < anc_count) begin
        if (ctr < rollover) begin
          anc_count = ctr;
          anc_secs = now;
        end else begin
          // Frames left up to the wrap; this goes negative for a large threshold.
          frames = 65536 - longint'(anc_count) - longint'(rollover);
          step_secs = (longint'(secs_per_period) * (frames < 0 ? -frames : frames))
                      / longint'(div);
          anc_secs = (frames < 0) ? anc_secs - step_secs[31:0] : anc_secs + step_secs[31:0];
          anc_count = '0;
        end
        r.changed = 1'b1;
      end else if (ctr > anc_count) begin
        lead = int'(ctr) - int'(anc_count);
        if (lead > lead_limit) begin
          quot = lead / div;
          anc_secs = anc_secs + secs_per_period * quot;
          anc_count = CNT_W'(anc_count + quot * div);
          r.changed = 1'b1;
        end
      end
      r.counter = anc_count;
      r.seconds = anc_secs;
      r.next_count = ctr + 1'b1;
      pending_anchors.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_anchor(anchor_result_t got);
      anchor_result_t want;
      if (pending_anchors.size() == 0) begin
        $display("%0t: result with no frame pending, actual counter %0h seconds %0h",
                 $time, got.counter, got.seconds);
        errors++;
      end else begin
        want = pending_anchors.pop_front();
        compare_field("anchor_changed", 32'(want.changed), 32'(got.changed));
        compare_field("anchor_counter", 32'(want.counter), 32'(got.counter));
        compare_field("anchor_seconds", want.seconds, got.seconds);
        compare_field("expected_next", 32'(want.next_count), 32'(got.next_count));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  int   stall_cycles = 0;
  logic [CNT_W-1:0]     ctr_track;
  logic [SECS_IN_W-1:0] now_track;
  anchor_checker sb = new();

  ftt_in_if  in_if();
  ftt_out_if out_if();
  ftt_cfg_if cfg_if();

  frame_counter_timestamp_tracker DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    anchor_result_t got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_frame(in_if.frame_counter, in_if.now_seconds);
      end
      if (out_if.valid && out_if.ready) begin
        got.changed = out_if.anchor_changed;
        got.counter = out_if.anchor_counter;
        got.seconds = out_if.anchor_seconds;
        got.next_count = out_if.expected_next;
        sb.check_anchor(got);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        sb.set_reg(cfg_if.index, cfg_if.data);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, stall_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // The receiver stalls at random, and once holds off long enough to back up the input.
  initial begin
    int  hold_left;
    int  taken;
    bit  held_once;
    hold_left = 0;
    taken = 0;
    held_once = 0;
    out_if.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) taken++;
      if (!held_once && taken >= 450) begin
        held_once = 1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(0, 99) >= 17);
      end
    end
  end

  task automatic send_frame(logic [CNT_W-1:0] ctr, logic [SECS_IN_W-1:0] now);
    while (!steady && $urandom_range(0, 99) < 17) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.frame_counter <= ctr;
    in_if.now_seconds <= now;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Drops the request and waits until every queued result has come back.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_anchors.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic program_regs(logic [CFG_W-1:0] spp, logic [CFG_W-1:0] rows,
                              logic [CFG_W-1:0] thr, logic [CFG_W-1:0] lim);
    logic [CFG_IDX_W-1:0] idx_list[4];
    logic [CFG_W-1:0]     val_list[4];
    idx_list = '{REG_SECONDS_PER_PERIOD, REG_ROWS_PER_PERIOD,
                 REG_ROLLOVER_THRESHOLD, REG_ADVANCE_LIMIT};
    val_list = '{spp, rows, thr, lim};
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx_list[i];
      cfg_if.data <= val_list[i];
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CFG_W'(1);
      2: return '1;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  task automatic random_regs();
    int mode;
    mode = $urandom_range(0, 3);
    if (mode < 2) begin
      program_regs(CFG_W'($urandom_range(1, 16)), CFG_W'($urandom_range(1, 32)),
                   CFG_W'($urandom_range(0, 64)), CFG_W'($urandom_range(0, 40)));
    end else if (mode == 2) begin
      program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                   CFG_W'($urandom));
    end else begin
      program_regs(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
    end
  endtask

  // Mostly a counting frame stream with a slow clock, plus jumps and pure noise.
  task automatic random_frames(int count);
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        if ($urandom_range(0, 15) == 0) ctr_track += CNT_W'($urandom_range(0, 40));
        else ctr_track += 1'b1;
        if ($urandom_range(0, 7) == 0) now_track += SECS_IN_W'($urandom_range(1, 3));
        send_frame(ctr_track, now_track);
      end else if (kind < 86) begin
        ctr_track = CNT_W'($urandom);
        send_frame(ctr_track, now_track);
      end else begin
        send_frame(CNT_W'($urandom), SECS_IN_W'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    steady = 0;
    in_if.valid = 1'b0;
    in_if.frame_counter = '0;
    in_if.now_seconds = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults: first frame, equal counter, wrap by one frame, advances.
    send_frame(16'hFFFF, 32'hFFFF_FFFF);
    send_frame(16'hFFFF, 32'h0000_0000);
    send_frame(16'h0000, 32'h0000_0000);
    send_frame(16'h0001, 32'h0000_0005);
    send_frame(16'hFFFF, 32'h0000_0007);
    send_frame(16'h0000, 32'h0000_0009);
    settle();

    // A threshold this high makes the wrap step negative.
    program_regs(16'hFFFF, 16'h0001, 16'h8000, 16'h0000);
    send_frame(16'hFFFF, 32'h0000_0123);
    send_frame(16'h9000, 32'h0000_0000);
    send_frame(16'h0000, 32'h0000_0000);
    send_frame(16'hFFFF, 32'h8000_0000);
    send_frame(16'h7FFF, 32'hDEAD_BEEF);
    send_frame(16'h8000, 32'h0000_0001);
    settle();

    // Zero rows is taken as one row, and zero seconds keeps the anchor seconds.
    program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0003);
    send_frame(16'h0010, 32'h0000_0001);
    send_frame(16'h0012, 32'h0000_0002);
    send_frame(16'h0014, 32'h0000_0003);
    send_frame(16'h0015, 32'h0000_0004);
    send_frame(16'h0016, 32'h0000_0005);
    settle();

    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_frame(16'h0000, 32'h5555_AAAA);
    send_frame(16'hFFFF, 32'hAAAA_5555);
    send_frame(16'hFFFE, 32'h0000_0000);
    settle();

    program_regs(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    send_frame(16'hFFFF, 32'h0000_0010);
    send_frame(16'h0001, 32'h0000_0011);
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_regs();
      steady = (phase == 2);
      ctr_track = CNT_W'($urandom);
      now_track = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                              : $urandom;
      random_frames(FRAMES_PER_PHASE);
      settle();
      steady = 0;
    end

    if (sb.pending_anchors.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending_anchors.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/ftt_pkg.sv
src/ftt_in_if.sv
src/ftt_out_if.sv
src/ftt_cfg_if.sv
src/ftt_ctrl.sv
src/ftt_datapath.sv
src/frame_counter_timestamp_tracker.sv
tb/testbench.sv
